### hw/rtl/one_way_scan_request_queue_defines.svh
// Assertion macros used by the queue RTL.
`ifndef ONE_WAY_SCAN_REQUEST_QUEUE_DEFINES_SVH
`define ONE_WAY_SCAN_REQUEST_QUEUE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define OWSQ_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define OWSQ_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### hw/rtl/owsq_pkg.sv
package owsq_pkg;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [15:0] cyl;
      logic [31:0] blk;
      logic [7:0]  tag;
   } entry_type;

   // per-cell load select for the current cycle
   typedef struct packed {
      logic load;        // take the new request
      logic from_left;   // take the entry of the slot below (insert shift)
      logic from_right;  // take the entry of the slot above (pop shift)
   } cell_ctrl_type;

endpackage

### hw/rtl/owsq_req_if.sv
interface owsq_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] cylinder;
   logic [31:0] block_number;
   logic [7:0]  request_tag;

   modport source (output valid, mode, cylinder, block_number, request_tag, input ready);
   modport sink (input valid, mode, cylinder, block_number, request_tag, output ready);
endinterface

### hw/rtl/owsq_rsp_if.sv
interface owsq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  position;
   logic [15:0] head_cylinder;
   logic [31:0] head_block;
   logic [7:0]  head_tag;
   logic [5:0]  occupancy;

   modport source (output valid, status, position, head_cylinder, head_block, head_tag,
                   occupancy, input ready);
   modport sink (input valid, status, position, head_cylinder, head_block, head_tag,
                 occupancy, output ready);
endinterface

### hw/rtl/owsq_cell.sv
module owsq_cell import owsq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   input  logic [15:0]   head_cyl,
   input  logic          new_below_head,
   output entry_type     entry,
   output logic          stop
);

   entry_type entry_ff;
   logic      new_first;
   logic      second_run;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         entry_ff <= new_entry;
      end else if (ctrl.from_left) begin
         entry_ff <= left_entry;
      end else if (ctrl.from_right) begin
         entry_ff <= right_entry;
      end
   end

   assign new_first = (new_entry.cyl < entry_ff.cyl) ||
                      ((new_entry.cyl == entry_ff.cyl) && (new_entry.blk < entry_ff.blk));

   // entries below the head cylinder form the second run
   assign second_run = entry_ff.cyl < head_cyl;

   // stop is monotone along the occupied slots: first set slot is the insert point
   assign stop  = new_below_head ? (new_first && second_run) : (new_first || second_run);
   assign entry = entry_ff;

endmodule

### hw/rtl/one_way_scan_request_queue.sv
// One-way scan disk request queue.
// req_port carries items: mode 0 inserts (cylinder, block_number, request_tag),
// mode 1 pops the head request. rsp_port returns one item per request item:
// status, the slot an insert went to, the popped head fields and the
// occupancy after the item.
// The queue is a row of QUEUE_DEPTH slot cells. Every cell compares the new
// request against its own entry and the head in parallel; on an insert the
// cells past the insert point shift one slot toward the tail, on a pop all
// cells shift toward the head. The response is registered, valid the cycle after
// acceptance. Throughput: one item per cycle while each response is taken, set by
// the cell compare and shift; the response register is the only stage.
// req_port.ready is high while the response register is empty or being taken,
// so a stalled receiver holds the response and blocks new items.
// Reset (synchronous) empties the queue and drops any pending response; slot
// contents are not cleared, only the occupancy count.
module one_way_scan_request_queue import owsq_pkg::*; #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   owsq_req_if.sink   req_port,
   owsq_rsp_if.source rsp_port
);

`include "one_way_scan_request_queue_defines.svh"

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic [4:0]    position_ff, position_in;
   entry_type     head_ff, head_in;
   logic [5:0]    occupancy_ff, occupancy_in;

   entry_type     new_entry;
   entry_type     cell_entry [QUEUE_DEPTH];
   cell_ctrl_type cell_ctrl [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] stop, ge, occupied, load_vec;

   logic          accept, is_full, is_empty, ins_fire, pop_fire, new_below_head;
   logic [IW-1:0] pos_idx;
   logic [IW+4:0] pos_ext;
   logic [CW+5:0] occ_ext;

   assign accept   = req_port.valid && req_port.ready;
   assign is_full  = count_ff == CW'(QUEUE_DEPTH);
   assign is_empty = count_ff == '0;
   assign ins_fire = accept && (req_port.mode == MODE_INSERT) && !is_full;
   assign pop_fire = accept && (req_port.mode == MODE_REMOVE) && !is_empty;

   assign new_entry.cyl = req_port.cylinder;
   assign new_entry.blk = req_port.block_number;
   assign new_entry.tag = req_port.request_tag;

   assign new_below_head = req_port.cylinder < cell_entry[0].cyl;

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      entry_type left_entry, right_entry;

      if (k == 0) begin : g_first
         assign left_entry = new_entry;
      end else begin : g_mid_left
         assign left_entry = cell_entry[k-1];
      end
      if (k == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[k];
      end else begin : g_mid_right
         assign right_entry = cell_entry[k+1];
      end

      owsq_cell u_cell (
         .clock          (clock),
         .ctrl           (cell_ctrl[k]),
         .new_entry      (new_entry),
         .left_entry     (left_entry),
         .right_entry    (right_entry),
         .head_cyl       (cell_entry[0].cyl),
         .new_below_head (new_below_head),
         .entry          (cell_entry[k]),
         .stop           (stop[k])
      );
   end

   // ge marks the slots at or after the insert point; slot 0 is never displaced
   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         occupied[k] = count_ff > CW'(k);
         if (k == 0) begin
            ge[k] = 1'b0;
         end else begin
            ge[k] = occupied[k] ? stop[k] : 1'b1;
         end
      end
   end

   always_comb begin
      pos_idx = '0;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (k == 0) begin
            load_vec[k] = is_empty;
            cell_ctrl[k].from_left = 1'b0;
         end else begin
            load_vec[k] = !is_empty && ge[k] && !ge[k-1];
            cell_ctrl[k].from_left = ins_fire && !is_empty && ge[k] && ge[k-1];
         end
         cell_ctrl[k].load       = ins_fire && load_vec[k];
         cell_ctrl[k].from_right = pop_fire;
         if (load_vec[k]) begin
            pos_idx = pos_idx | IW'(k);
         end
      end
   end

   assign pos_ext = {5'd0, pos_idx};
   assign occ_ext = {6'd0, count_in};

   always_comb begin
      count_in    = count_ff;
      status_in   = STATUS_DONE;
      position_in = '0;
      head_in     = '0;
      if (req_port.mode == MODE_INSERT) begin
         if (is_full) begin
            status_in = STATUS_FULL;
         end else begin
            position_in = pos_ext[4:0];
            count_in    = count_ff + CW'(1);
         end
      end else begin
         if (is_empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            head_in  = cell_entry[0];
            count_in = count_ff - CW'(1);
         end
      end
      occupancy_in = occ_ext[5:0];
   end

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign rsp_valid_in   = accept || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         position_ff  <= position_in;
         head_ff      <= head_in;
         occupancy_ff <= occupancy_in;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.status        = status_ff;
   assign rsp_port.position      = position_ff;
   assign rsp_port.head_cylinder = head_ff.cyl;
   assign rsp_port.head_block    = head_ff.blk;
   assign rsp_port.head_tag      = head_ff.tag;
   assign rsp_port.occupancy     = occupancy_ff;

   `OWSQ_ASSERT_SAME(a_one_insert_slot, clock, reset, ins_fire, $onehot(load_vec), "insert point not unique")
   `OWSQ_ASSERT_NEXT(a_insert_count, clock, reset, ins_fire, count_ff == $past(count_ff) + CW'(1), "count did not grow on insert")
   `OWSQ_ASSERT_NEXT(a_pop_count, clock, reset, pop_fire, count_ff == $past(count_ff) - CW'(1), "count did not shrink on pop")
   `OWSQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(QUEUE_DEPTH), "count above depth")

endmodule
